@@ rtl/iiss_pkg.sv @@
// ----------------------------------------------------------------------------
// iiss_pkg
// Shared constants and types of the integral image sum and squares block.
// ----------------------------------------------------------------------------
package iiss_pkg;

  localparam int PIX_W = 8;
  localparam int SUM_W = 32;
  localparam int SQ_W = 40;
  localparam int PSQ_W = 2 * PIX_W;
  localparam int CFG_W = 11;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

  // output queue depth: one word leaving, one in flight, one arriving
  localparam int FIFO_DEPTH = 3;
  localparam int PTR_W = 2;
  localparam int CNT_W = 2;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_NARROW = 2'd2
  } reg_addr_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic             row_last;
    logic             frame_last;
  } out_word_t;

endpackage

@@ rtl/integral_image_sum_and_squares.sv @@
// ----------------------------------------------------------------------------
// integral_image_sum_and_squares
// Summed-area table of pixels and of squared pixels, raster-order stream,
// with running row sums and a line store holding the previous row.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               word
//  pixel     in         in_valid / in_ready     pixel
//  result    out        out_valid / out_ready   area_sum, area_square_sum,
//                                               row_last, frame_last
//  config    in         psel/penable/pwrite     image_width, image_height,
//                                               narrow_squares
//
//  one pixel per clock while in_ready is high; a result passes write-back, then the queue
//  (line store read at the accept edge, combine and write-back in the next cycle)
//  back-to-back accesses to the same column are forwarded from write-back
//  a three-word output queue absorbs stalls; in_ready drops when the queue and
//  the write-back stage together hold three words
//  reset clears counters and row sums; the line store needs no clearing pass
// ----------------------------------------------------------------------------
module integral_image_sum_and_squares #(
  parameter int MAX_WIDTH = iiss_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iiss_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iiss_pkg::ADDR_W-1:0]   paddr,
  input  logic [iiss_pkg::DATA_W-1:0]   pwdata,
  output logic [iiss_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iiss_pkg::PIX_W-1:0]    pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iiss_pkg::SUM_W-1:0]    area_sum,
  output logic [iiss_pkg::SQ_W-1:0]     area_square_sum,
  output logic                          row_last,
  output logic                          frame_last
);
  import iiss_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic             cfg_narrow;
  reg_addr_t        reg_sel;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign reg_sel = reg_addr_t'(paddr[3:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      cfg_narrow <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  cfg_width <= pwdata[CFG_W-1:0];
        REG_HEIGHT: cfg_height <= pwdata[CFG_W-1:0];
        REG_NARROW: cfg_narrow <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(cfg_width);
      REG_HEIGHT: prdata = DATA_W'(cfg_height);
      REG_NARROW: prdata = DATA_W'(cfg_narrow);
      default:    prdata = '0;
    endcase
  end

  // frame size, zero taken as one and saturated at the maximum
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;

  always_comb begin
    if (cfg_width == '0) begin
      width_eff = WW'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      height_eff = HW'(1);
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(cfg_height);
    end
  end

  // accept stage: counters, row sums, line store read
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [SUM_W-1:0] row_sum;
  logic [SQ_W-1:0]  row_sq;
  logic [CW-1:0]    col_next;
  logic [RW-1:0]    row_next;
  logic [SUM_W-1:0] row_sum_next;
  logic [SQ_W-1:0]  row_sq_next;
  logic [SUM_W-1:0] row_sum_add;
  logic [SQ_W-1:0]  row_sq_add;
  logic [PSQ_W-1:0] pix_sq;
  logic             row_end;
  logic             frame_end;
  logic             in_acc;
  logic [CNT_W-1:0] q_count;
  logic             s1_valid;

  assign in_ready = ({1'b0, q_count} + {{CNT_W{1'b0}}, s1_valid}) < (CNT_W + 1)'(FIFO_DEPTH);
  assign in_acc = in_valid && in_ready;

  assign pix_sq = PSQ_W'(pixel) * PSQ_W'(pixel);
  assign row_sum_add = row_sum + SUM_W'(pixel);

  always_comb begin
    row_sq_add = row_sq + SQ_W'(pix_sq);
    if (cfg_narrow) begin
      row_sq_add[SQ_W-1:SUM_W] = '0;
    end
  end

  assign row_end = (WW'(col) + WW'(1)) >= width_eff;
  assign frame_end = row_end && ((HW'(row) + HW'(1)) >= height_eff);

  always_comb begin
    if (row_end) begin
      col_next = '0;
      row_sum_next = '0;
      row_sq_next = '0;
      row_next = frame_end ? '0 : row + RW'(1);
    end else begin
      col_next = col + CW'(1);
      row_sum_next = row_sum_add;
      row_sq_next = row_sq_add;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      row_sum <= '0;
      row_sq <= '0;
    end else if (in_acc) begin
      col <= col_next;
      row <= row_next;
      row_sum <= row_sum_next;
      row_sq <= row_sq_next;
    end
  end

  // line store of the previous row
  logic [SUM_W-1:0] sum_mem [MAX_WIDTH];
  logic [SQ_W-1:0]  sq_mem [MAX_WIDTH];
  logic [SUM_W-1:0] rd_sum;
  logic [SQ_W-1:0]  rd_sq;

  // write-back stage
  logic [CW-1:0]    s1_col;
  logic             s1_first;
  logic [SUM_W-1:0] s1_rsum;
  logic [SQ_W-1:0]  s1_rsq;
  logic             s1_row_end;
  logic             s1_frame_end;
  logic             s1_narrow;
  logic [SUM_W-1:0] above_sum;
  logic [SQ_W-1:0]  above_sq;
  logic [SUM_W-1:0] sum_c;
  logic [SQ_W-1:0]  sq_c;

  // last write-back, for a read issued in the same cycle as that write
  logic             wr_valid;
  logic [CW-1:0]    wr_col;
  logic [SUM_W-1:0] wr_sum;
  logic [SQ_W-1:0]  wr_sq;
  logic             fwd;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_sum <= sum_mem[col];
      rd_sq <= sq_mem[col];
    end
    if (s1_valid) begin
      sum_mem[s1_col] <= sum_c;
      sq_mem[s1_col] <= sq_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
      wr_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col <= col;
      s1_first <= (row == '0);
      s1_rsum <= row_sum_add;
      s1_rsq <= row_sq_add;
      s1_row_end <= row_end;
      s1_frame_end <= frame_end;
      s1_narrow <= cfg_narrow;
    end
    if (s1_valid) begin
      wr_col <= s1_col;
      wr_sum <= sum_c;
      wr_sq <= sq_c;
    end
  end

  assign fwd = wr_valid && (wr_col == s1_col);

  always_comb begin
    if (s1_first) begin
      above_sum = '0;
      above_sq = '0;
    end else if (fwd) begin
      above_sum = wr_sum;
      above_sq = wr_sq;
    end else begin
      above_sum = rd_sum;
      above_sq = rd_sq;
    end
    sum_c = above_sum + s1_rsum;
    sq_c = above_sq + s1_rsq;
    if (s1_narrow) begin
      sq_c[SQ_W-1:SUM_W] = '0;
    end
  end

  out_word_t push_word;
  out_word_t pop_word;

  assign push_word = '{sum: sum_c, sq: sq_c, row_last: s1_row_end, frame_last: s1_frame_end};

  iiss_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_word (push_word),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_word  (pop_word),
    .count     (q_count)
  );

  assign area_sum = pop_word.sum;
  assign area_square_sum = pop_word.sq;
  assign row_last = pop_word.row_last;
  assign frame_last = pop_word.frame_last;

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(col) < MAX_WIDTH)
    else $error("column counter beyond line store");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && row_end) |=> (col == '0 && row_sum == '0))
    else $error("row state not cleared at end of row");

  a_narrow_sq: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_narrow) |-> (sq_c[SQ_W-1:SUM_W] == '0))
    else $error("narrow square sum has high bits set");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_frame_end) |-> s1_row_end)
    else $error("frame end without row end");

endmodule

@@ rtl/iiss_out_fifo.sv @@
// ----------------------------------------------------------------------------
// iiss_out_fifo
// Small output queue that decouples the result path from downstream stalls.
// ----------------------------------------------------------------------------
module iiss_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  iiss_pkg::out_word_t push_word,
  input  logic                pop_ready,
  output logic                pop_valid,
  output iiss_pkg::out_word_t pop_word,
  output logic [iiss_pkg::CNT_W-1:0] count
);
  import iiss_pkg::*;

  out_word_t        entries [FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic             pop;

  assign pop_valid = (count != '0);
  assign pop = pop_valid && pop_ready;
  assign pop_word = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (pop) begin
        head <= (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != CNT_W'(FIFO_DEPTH)))
    else $error("output queue overflow");

endmodule

@@ verif/integral_image_sum_and_squares_test.sv @@
// ----------------------------------------------------------------------------
// integral_image_sum_and_squares_test
// Self-checking testbench for the integral image block: pixels stream in over
// valid/ready, a local model predicts each summed-area word (pixel sum, square
// sum, row and frame flags), and the checker compares every word in order.
// Register writes and readbacks go through the APB-style port while idle.
// ----------------------------------------------------------------------------
module integral_image_sum_and_squares_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iiss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned LINE_DEPTH = 1024;
  localparam int unsigned RANDOM_PIXELS = 600;

  typedef enum logic [1:0] {
    GAP_NORMAL,
    GAP_NONE,
    GAP_RARE
  } gap_mode_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [PIX_W-1:0]    pixel;
  logic                out_valid;
  logic                out_ready;
  logic [SUM_W-1:0]    area_sum;
  logic [SQ_W-1:0]     area_square_sum;
  logic                row_last;
  logic                frame_last;

  // register copies
  logic [CFG_W-1:0]    cfg_width;
  logic [CFG_W-1:0]    cfg_height;
  logic                cfg_narrow;

  // integral image state
  logic [SUM_W-1:0]    run_sum;
  logic [SQ_W-1:0]     run_sq;
  logic [SUM_W-1:0]    line_sum [0:LINE_DEPTH-1];
  logic [SQ_W-1:0]     line_sq [0:LINE_DEPTH-1];
  int unsigned         col_idx;
  int unsigned         row_idx;
  int unsigned         line_extent;  // columns of the line store ever written

  out_word_t           expected_words[$];

  gap_mode_t           src_mode;
  gap_mode_t           sink_mode;
  int unsigned         mismatches;
  int unsigned         pixels_sent;
  int unsigned         words_checked;
  int unsigned         frames_closed;
  int unsigned         reg_writes;
  int unsigned         cycle_count;

  integral_image_sum_and_squares u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pixel           (pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .area_sum        (area_sum),
    .area_square_sum (area_square_sum),
    .row_last        (row_last),
    .frame_last      (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("integral_image_sum_and_squares regression: fail");
      $finish;
    end
  end

  function automatic void note_mismatch(input string what, input logic [SQ_W-1:0] want,
                                        input logic [SQ_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected 0x%0h got 0x%0h", what, want, got);
  endfunction

  function automatic int unsigned span(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > LINE_DEPTH) return LINE_DEPTH;
    return v;
  endfunction

  function automatic int draw_gap(input gap_mode_t m);
    case (m)
      GAP_NONE: return 0;
      GAP_RARE: return ($urandom_range(0, 31) == 0) ? $urandom_range(1, 19) : 0;
      default:  return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic gap_mode_t pick_mode();
    case ($urandom_range(0, 9))
      0, 1:    return GAP_NONE;
      2:       return GAP_RARE;
      default: return GAP_NORMAL;
    endcase
  endfunction

  // advance the integral image by one pixel and queue the word it yields
  function automatic void integrate_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    logic [SQ_W-1:0] sq_mask;
    logic [SUM_W-1:0] above_sum;
    logic [SQ_W-1:0] above_sq;
    out_word_t word;
    w = span(cfg_width);
    h = span(cfg_height);
    sq_mask = cfg_narrow ? 40'h00_FFFF_FFFF : 40'hFF_FFFF_FFFF;
    col = (col_idx >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_idx;
    run_sum = run_sum + SUM_W'(pix);
    run_sq = (run_sq + SQ_W'(pix) * SQ_W'(pix)) & sq_mask;
    above_sum = '0;
    above_sq = '0;
    if (row_idx != 0) begin
      above_sum = line_sum[col];
      above_sq = line_sq[col];
    end
    word.sum = above_sum + run_sum;
    word.sq = (above_sq + run_sq) & sq_mask;
    line_sum[col] = word.sum;
    line_sq[col] = word.sq;
    if (col + 1 > line_extent) line_extent = col + 1;
    word.row_last = (col_idx + 1 >= w);
    word.frame_last = word.row_last && (row_idx + 1 >= h);
    if (word.row_last) begin
      col_idx = 0;
      run_sum = '0;
      run_sq = '0;
      row_idx = word.frame_last ? 0 : row_idx + 1;
    end else begin
      col_idx = col_idx + 1;
    end
    expected_words.push_back(word);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = draw_gap(src_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    do @(posedge clk); while (in_ready !== 1'b1);
    integrate_pixel(pix);
    pixels_sent++;
  endtask

  // stop the stream and let every outstanding word come out
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input reg_addr_t r, input logic write,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {r, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_check(input reg_addr_t r, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] got;
    apb_access(r, 1'b0, '0, got);
    if (got !== want) note_mismatch({r.name(), " readback"}, SQ_W'(want), SQ_W'(got));
  endtask

  // unused upper data bits carry noise, the register keeps only its own bits
  task automatic set_reg(input reg_addr_t r, input logic [CFG_W-1:0] value);
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] ignored;
    logic [CFG_W-1:0] kept;
    drain_words();
    data = $urandom();
    if (r == REG_NARROW) begin
      data[0] = value[0];
      kept = {10'd0, value[0]};
    end else begin
      data[CFG_W-1:0] = value;
      kept = value;
    end
    apb_access(r, 1'b1, data, ignored);
    case (r)
      REG_WIDTH:  cfg_width = kept;
      REG_HEIGHT: cfg_height = kept;
      default:    cfg_narrow = kept[0];
    endcase
    reg_writes++;
    read_check(r, DATA_W'(kept));
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] bright_pixel();
    return ($urandom_range(0, 15) == 0) ? PIX_W'($urandom_range(0, 255)) : 8'hFF;
  endfunction

  task automatic test_register_access();
    read_check(REG_WIDTH, DATA_W'(WIDTH_RESET));
    read_check(REG_HEIGHT, DATA_W'(HEIGHT_RESET));
    read_check(REG_NARROW, '0);
    set_reg(REG_WIDTH, 11'h7FF);
    set_reg(REG_HEIGHT, 11'd0);
    set_reg(REG_NARROW, 1'b1);
    set_reg(REG_WIDTH, 11'd1);
    set_reg(REG_HEIGHT, 11'h7FF);
    set_reg(REG_NARROW, 1'b0);
  endtask

  task automatic test_pixel_extremes();
    logic [PIX_W-1:0] pattern [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
    set_reg(REG_WIDTH, 11'd3);
    set_reg(REG_HEIGHT, 11'd2);
    foreach (pattern[i]) send_pixel(pattern[i]);
  endtask

  // zero sizes act as one: every pixel closes its row and its frame
  task automatic test_degenerate_sizes();
    set_reg(REG_WIDTH, 11'd0);
    set_reg(REG_HEIGHT, 11'd0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_mid_frame_resize();
    set_reg(REG_WIDTH, 11'd4);
    set_reg(REG_HEIGHT, 11'd3);
    repeat (6) send_pixel(random_pixel());
    // column already past the new row end: the next pixel closes the row
    set_reg(REG_WIDTH, 11'd2);
    send_pixel(random_pixel());
    // row counter past the new height: this row closes the frame
    set_reg(REG_HEIGHT, 11'd2);
    repeat (2) send_pixel(random_pixel());
  endtask

  // rows of bright pixels over several lines grow the square sum fast,
  // switching to narrow squares partway through the frame
  task automatic test_square_wrap();
    src_mode = GAP_RARE;
    sink_mode = GAP_RARE;
    set_reg(REG_NARROW, 1'b0);
    set_reg(REG_WIDTH, 11'd40);
    set_reg(REG_HEIGHT, 11'd1100);
    repeat (80) send_pixel(bright_pixel());
    set_reg(REG_NARROW, 1'b1);
    repeat (40) send_pixel(bright_pixel());
    set_reg(REG_HEIGHT, 11'd3);
    set_reg(REG_WIDTH, 11'd4);
    repeat (4) send_pixel(bright_pixel());
    src_mode = GAP_NORMAL;
    sink_mode = GAP_NORMAL;
  endtask

  task automatic test_random_frames();
    int unsigned done;
    int unsigned n;
    int unsigned area;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    done = 0;
    while (done < RANDOM_PIXELS) begin
      src_mode = pick_mode();
      sink_mode = pick_mode();
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 15))
            0:       w = 11'd0;
            1:       w = 11'h7FF;
            2:       w = 11'd1024;
            3, 4, 5, 6, 7, 8, 9: w = CFG_W'($urandom_range(1, 8));
            default: w = CFG_W'($urandom_range(9, 64));
          endcase
          // a wider row mid-frame may only reach line store columns already filled
          if (row_idx != 0 && span(w) > line_extent) w = CFG_W'(line_extent);
          case ($urandom_range(0, 7))
            0:       h = 11'd0;
            1:       h = 11'h7FF;
            default: h = CFG_W'($urandom_range(1, 6));
          endcase
          set_reg(REG_WIDTH, w);
          set_reg(REG_HEIGHT, h);
          set_reg(REG_NARROW, 1'($urandom_range(0, 1)));
        end
        1: set_reg(REG_NARROW, ~cfg_narrow);
        2: set_reg(REG_HEIGHT, CFG_W'($urandom_range(1, 6)));
        default: ;
      endcase
      area = span(cfg_width) * span(cfg_height);
      n = (area <= 150) ? area * $urandom_range(1, 2) : $urandom_range(20, 150);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 5);
      repeat (n) send_pixel(random_pixel());
      done += n;
    end
  endtask

  // result receiver: random back-pressure per word
  initial begin
    int gap;
    forever begin
      gap = draw_gap(sink_mode);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word, area_sum", '0, SQ_W'(area_sum));
      end else begin
        want = expected_words.pop_front();
        if (area_sum !== want.sum)
          note_mismatch("area_sum", SQ_W'(want.sum), SQ_W'(area_sum));
        if (area_square_sum !== want.sq)
          note_mismatch("area_square_sum", want.sq, area_square_sum);
        if (row_last !== want.row_last)
          note_mismatch("row_last", SQ_W'(want.row_last), SQ_W'(row_last));
        if (frame_last !== want.frame_last)
          note_mismatch("frame_last", SQ_W'(want.frame_last), SQ_W'(frame_last));
        words_checked++;
        if (want.frame_last) frames_closed++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    pixel = '0;
    out_ready = 1'b0;
    cycle_count = 0;
    mismatches = 0;
    pixels_sent = 0;
    words_checked = 0;
    frames_closed = 0;
    reg_writes = 0;
    src_mode = GAP_NORMAL;
    sink_mode = GAP_NORMAL;
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    cfg_narrow = 1'b0;
    run_sum = '0;
    run_sq = '0;
    col_idx = 0;
    row_idx = 0;
    line_extent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_pixel_extremes();
    test_degenerate_sizes();
    test_mid_frame_resize();
    test_square_wrap();
    test_random_frames();

    drain_words();
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0)
      note_mismatch("words never delivered", '0, SQ_W'(expected_words.size()));
    $display("streamed %0d pixels, checked %0d words over %0d frames", pixels_sent,
             words_checked, frames_closed);
    $display("%0d register writes with readback, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0)
      $display("integral_image_sum_and_squares regression: pass");
    else
      $display("integral_image_sum_and_squares regression: fail");
    $finish;
  end

endmodule
